>>> rtl/sogi_quadrature_filter_core_macros.svh
// Assertion helpers used by the filter RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef SOGI_QUADRATURE_FILTER_CORE_MACROS_SVH
`define SOGI_QUADRATURE_FILTER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SQF_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SQF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sqf_pkg.sv
package sqf_pkg;

	// Default sample and coefficient widths.
	localparam int SAMPLE_WIDTH_DEF = 24;
	localparam int COEF_WIDTH_DEF   = 32;

	// The accumulator wraps modulo 2^64, as the fixed-point algorithm defines it.
	localparam int ACC_W = 64;

	// Coefficient reset values in Q2.30.
	localparam logic signed [31:0] B0_RESET  = 32'sd8365200;
	localparam logic signed [31:0] A1_RESET  = 32'sd2129692000;
	localparam logic signed [31:0] A2_RESET  = -32'sd1057013000;
	localparam logic signed [31:0] QB0_RESET = 32'sd131400;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_B0  = 2'd0,
		CFG_A1  = 2'd1,
		CFG_A2  = 2'd2,
		CFG_QB0 = 2'd3
	} cfg_idx_t;

endpackage

>>> rtl/sogi_quadrature_filter_core.sv
// SOGI quadrature filter core (Tustin-discretized second-order integrator).
// Input: one signed Q2.(SAMPLE_WIDTH-2) sample per beat on s_tvalid/s_tready/s_tdata.
// Output: one beat per input beat on m_tvalid/m_tready with the in-phase and
// quadrature outputs in m_tdata and the clip flag in m_tuser.
// Coefficients are written through cfg_we/cfg_index/cfg_data while the core
// is idle; each write takes effect at the clock edge where cfg_we is high.
// An accepted input beat is registered first in the input stage (valid_s1,
// x_s1) and then in the output register (out_valid_q), which drives m_tvalid.
// Throughput is one beat per cycle while m_tready stays high: the six
// multipliers, the two adder trees and the round/saturate logic all sit
// between the input stage and the output register, and the feedback taps close on that same path.
// Reset clears the filter history to zero, loads the default coefficients
// and empties both stages. When the receiver holds m_tready low, the output
// register keeps its beat, the input stage fills behind it, and s_tready
// drops once both are occupied; nothing is lost or repeated.
module sogi_quadrature_filter_core #(
	parameter int SAMPLE_WIDTH = sqf_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = sqf_pkg::COEF_WIDTH_DEF,
	localparam int IN_W        = ((SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int OUT_W       = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Coefficient write port.
	input  logic                           cfg_we,
	input  logic [sqf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [COEF_WIDTH-1:0]          cfg_data,
	// Sample input.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [IN_W-1:0]                s_tdata,  // in_sample
	// Filter output.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [OUT_W-1:0]               m_tdata,  // inphase_out, quadrature_out
	output logic [0:0]                     m_tuser   // saturated
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int CW = COEF_WIDTH;
	localparam int AW = sqf_pkg::ACC_W;
	localparam int FRAC = CW - 2;
	localparam logic signed [AW-1:0] RND = AW'(1) << (FRAC - 1);
	localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};

	// Coefficient registers.
	logic signed [CW-1:0] coef_b0_q, coef_a1_q, coef_a2_q, coef_qb0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_b0_q  <= CW'(sqf_pkg::B0_RESET);
			coef_a1_q  <= CW'(sqf_pkg::A1_RESET);
			coef_a2_q  <= CW'(sqf_pkg::A2_RESET);
			coef_qb0_q <= CW'(sqf_pkg::QB0_RESET);
		end else if (cfg_we) begin
			unique case (sqf_pkg::cfg_idx_t'(cfg_index))
				sqf_pkg::CFG_B0:  coef_b0_q  <= cfg_data;
				sqf_pkg::CFG_A1:  coef_a1_q  <= cfg_data;
				sqf_pkg::CFG_A2:  coef_a2_q  <= cfg_data;
				sqf_pkg::CFG_QB0: coef_qb0_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the input stage moves on when the output register is free.
	logic valid_s1;
	logic signed [SW-1:0] x_s1;
	logic out_valid_q;
	logic out_free, advance;

	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (out_free) out_valid_q <= valid_s1;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) x_s1 <= s_tdata[SW-1:0];
	end

	// Filter history.
	logic signed [SW-1:0] in_d1_q, in_d2_q, inph_d1_q, inph_d2_q, quad_d1_q, quad_d2_q;

	// Input combinations for the two branches.
	logic signed [SW:0]   diff;
	logic signed [SW+1:0] qsum;

	assign diff = (SW + 1)'(x_s1) - (SW + 1)'(in_d2_q);
	assign qsum = (SW + 2)'(x_s1) + ((SW + 2)'(in_d1_q) <<< 1) + (SW + 2)'(in_d2_q);

	// Six products in parallel.
	logic signed [CW+SW:0]   p_b0;
	logic signed [CW+SW+1:0] p_qb0;
	logic signed [CW+SW-1:0] p_a1v, p_a2v, p_a1q, p_a2q;

	assign p_b0  = (CW + SW + 1)'(coef_b0_q) * (CW + SW + 1)'(diff);
	assign p_qb0 = (CW + SW + 2)'(coef_qb0_q) * (CW + SW + 2)'(qsum);
	assign p_a1v = (CW + SW)'(coef_a1_q) * (CW + SW)'(inph_d1_q);
	assign p_a2v = (CW + SW)'(coef_a2_q) * (CW + SW)'(inph_d2_q);
	assign p_a1q = (CW + SW)'(coef_a1_q) * (CW + SW)'(quad_d1_q);
	assign p_a2q = (CW + SW)'(coef_a2_q) * (CW + SW)'(quad_d2_q);

	// Sums wrap at the accumulator width, then round half up.
	logic signed [AW-1:0] acc_v, acc_q, sh_v, sh_q;

	assign acc_v = AW'(p_b0) + AW'(p_a1v) + AW'(p_a2v) + RND;
	assign acc_q = AW'(p_qb0) + AW'(p_a1q) + AW'(p_a2q) + RND;
	assign sh_v  = acc_v >>> FRAC;
	assign sh_q  = acc_q >>> FRAC;

	// Saturate: the value fits when every bit above the sample sign matches it.
	logic fit_v, fit_q;
	logic signed [SW-1:0] v0, q0;

	assign fit_v = (&sh_v[AW-1:SW-1]) || !(|sh_v[AW-1:SW-1]);
	assign fit_q = (&sh_q[AW-1:SW-1]) || !(|sh_q[AW-1:SW-1]);
	assign v0 = fit_v ? sh_v[SW-1:0] : (sh_v[AW-1] ? S_MIN : S_MAX);
	assign q0 = fit_q ? sh_q[SW-1:0] : (sh_q[AW-1] ? S_MIN : S_MAX);

	// History advances together with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_d1_q   <= '0;
			in_d2_q   <= '0;
			inph_d1_q <= '0;
			inph_d2_q <= '0;
			quad_d1_q <= '0;
			quad_d2_q <= '0;
		end else if (advance) begin
			in_d1_q   <= x_s1;
			in_d2_q   <= in_d1_q;
			inph_d1_q <= v0;
			inph_d2_q <= inph_d1_q;
			quad_d1_q <= q0;
			quad_d2_q <= quad_d1_q;
		end
	end

	// Output register payload.
	logic signed [SW-1:0] inph_q, quad_q;
	logic sat_q;

	always_ff @(posedge clk) begin
		if (advance) begin
			inph_q <= v0;
			quad_q <= q0;
			sat_q  <= !(fit_v && fit_q);
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = OUT_W'({quad_q, inph_q});
	assign m_tuser[0] = sat_q;

	// Checks on the pipeline and the feedback path.
	`include "sogi_quadrature_filter_core_macros.svh"

	`SQF_ASSERT_NEXT(a_no_phantom_beat, !valid_s1 && out_free, !out_valid_q, "output beat without a source sample")
	`SQF_ASSERT_NEXT(a_input_history, advance, in_d1_q == $past(x_s1), "input history missed the sample")
	`SQF_ASSERT_NEXT(a_feedback_matches_out, advance, inph_d1_q == inph_q && quad_d1_q == quad_q, "fed-back outputs differ from the delivered beat")
	`SQF_ASSERT_SAME(a_sat_at_rail, out_valid_q && sat_q, inph_q == S_MAX || inph_q == S_MIN || quad_q == S_MAX || quad_q == S_MIN, "clip flag set with no output at a rail")

endmodule

>>> verif/sogi_quadrature_filter_core_tb.sv
module sogi_quadrature_filter_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_W = sqf_pkg::SAMPLE_WIDTH_DEF;
	localparam int COEF_W = sqf_pkg::COEF_WIDTH_DEF;
	localparam int IN_W = ((SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_W = ((2 * SAMPLE_W + 7) / 8) * 8;
	localparam int FRAC_SHIFT = COEF_W - 2;
	localparam longint ROUND_HALF = longint'(1) <<< (FRAC_SHIFT - 1);
	localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
	localparam int PHASE_COUNT = 8;
	localparam int SAMPLES_PER_PHASE = 154;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct {
		logic signed [SAMPLE_W-1:0] inphase;
		logic signed [SAMPLE_W-1:0] quad;
		logic saturated;
	} filter_result_t;

	// Fixed-point model of the filter plus the queue of outputs still owed by the core.
	class sogi_scoreboard;
		logic signed [COEF_W-1:0] b0, a1, a2, qb0;
		logic signed [SAMPLE_W-1:0] x_d1, x_d2, v_d1, v_d2, q_d1, q_d2;
		filter_result_t owed_q[$];
		int error_count;

		function new();
			b0 = sqf_pkg::B0_RESET;
			a1 = sqf_pkg::A1_RESET;
			a2 = sqf_pkg::A2_RESET;
			qb0 = sqf_pkg::QB0_RESET;
			x_d1 = '0;
			x_d2 = '0;
			v_d1 = '0;
			v_d2 = '0;
			q_d1 = '0;
			q_d2 = '0;
			error_count = 0;
		endfunction

		function void set_coef(sqf_pkg::cfg_idx_t idx, logic [COEF_W-1:0] value);
			unique case (idx)
				sqf_pkg::CFG_B0: b0 = value;
				sqf_pkg::CFG_A1: a1 = value;
				sqf_pkg::CFG_A2: a2 = value;
				sqf_pkg::CFG_QB0: qb0 = value;
				default: ;
			endcase
		endfunction

		// Round half up to the sample format, then clip to the sample range.
		function logic signed [SAMPLE_W-1:0] round_sat(longint acc, inout bit clip);
			longint rounded;
			rounded = (acc + ROUND_HALF) >>> FRAC_SHIFT;
			if (rounded > SAMPLE_MAX) begin
				clip = 1'b1;
				rounded = SAMPLE_MAX;
			end else if (rounded < SAMPLE_MIN) begin
				clip = 1'b1;
				rounded = SAMPLE_MIN;
			end
			return rounded[SAMPLE_W-1:0];
		endfunction

		// An input beat was accepted: compute both outputs and advance the history.
		function void note_sample(logic signed [SAMPLE_W-1:0] x0);
			longint acc;
			bit clip;
			filter_result_t res;
			clip = 1'b0;
			acc = longint'(b0) * longint'(x0) - longint'(b0) * longint'(x_d2)
				+ longint'(a1) * longint'(v_d1) + longint'(a2) * longint'(v_d2);
			res.inphase = round_sat(acc, clip);
			acc = longint'(qb0) * (longint'(x0) + 2 * longint'(x_d1) + longint'(x_d2))
				+ longint'(a1) * longint'(q_d1) + longint'(a2) * longint'(q_d2);
			res.quad = round_sat(acc, clip);
			res.saturated = clip;
			x_d2 = x_d1;
			x_d1 = x0;
			v_d2 = v_d1;
			v_d1 = res.inphase;
			q_d2 = q_d1;
			q_d1 = res.quad;
			owed_q.push_back(res);
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		function void flag(string field, logic signed [SAMPLE_W-1:0] want,
			logic signed [SAMPLE_W-1:0] got);
			error_count++;
			$display("%0t ns: mismatch on %s: expected %0d, actual %0d",
				$time, field, want, got);
		endfunction

		// An output beat was accepted: compare it with the oldest owed result.
		function void check_result(logic [OUT_W-1:0] tdata, logic [0:0] tuser);
			filter_result_t want;
			logic signed [SAMPLE_W-1:0] got_i, got_q;
			if (owed_q.size() == 0) begin
				error_count++;
				$display("%0t ns: output beat with nothing owed: expected none, actual %h/%b",
					$time, tdata, tuser);
				return;
			end
			want = owed_q.pop_front();
			got_i = tdata[SAMPLE_W-1:0];
			got_q = tdata[2*SAMPLE_W-1:SAMPLE_W];
			if (got_i !== want.inphase)
				flag("inphase_out", want.inphase, got_i);
			if (got_q !== want.quad)
				flag("quadrature_out", want.quad, got_q);
			if (tuser[0] !== want.saturated)
				flag("saturated", SAMPLE_W'(want.saturated), SAMPLE_W'(tuser[0]));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [sqf_pkg::CFG_IDX_W-1:0] cfg_index = sqf_pkg::CFG_B0;
	logic [COEF_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;	// in_sample
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;	// inphase_out, quadrature_out
	logic [0:0] m_tuser;	// saturated

	sogi_scoreboard sb;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int hold_cycles = 0;
	int quiet_cycles = 0;

	sogi_quadrature_filter_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Receiver: a long hold-off when requested, otherwise random stalls.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// Output beats are checked on the edge where they are taken.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
	end

	// Watchdog on cycles without any beat on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one sample, idling first at the configured rate, and wait for the beat.
	task automatic send_sample(logic signed [SAMPLE_W-1:0] x);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= IN_W'(x);
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_sample(x);
	endtask

	// Stop offering and let every owed result come out.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_coef(sqf_pkg::cfg_idx_t idx, logic [COEF_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.set_coef(idx, value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_coefs(logic [COEF_W-1:0] b0, logic [COEF_W-1:0] a1,
		logic [COEF_W-1:0] a2, logic [COEF_W-1:0] qb0);
		drain();
		write_coef(sqf_pkg::CFG_B0, b0);
		write_coef(sqf_pkg::CFG_A1, a1);
		write_coef(sqf_pkg::CFG_A2, a2);
		write_coef(sqf_pkg::CFG_QB0, qb0);
	endtask

	// Mix of full-range, small, extreme, single-bit and single-cleared-bit samples.
	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		int k;
		k = $urandom_range(0, SAMPLE_W - 1);
		case ($urandom_range(0, 7))
			0, 1, 2, 3: return SAMPLE_W'($urandom);
			4, 5: return SAMPLE_W'(int'($urandom_range(0, 4095)) - 2048);
			6: return $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(SAMPLE_MIN);
			default: return $urandom_range(0, 1) ? SAMPLE_W'(1) << k : ~(SAMPLE_W'(1) << k);
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] small_coef();
		return COEF_W'(int'($urandom_range(0, (1 << 29) - 1)) - (1 << 28));
	endfunction

	localparam logic signed [SAMPLE_W-1:0] STEP_MAX = SAMPLE_W'(SAMPLE_MAX);
	localparam logic signed [SAMPLE_W-1:0] STEP_MIN = SAMPLE_W'(SAMPLE_MIN);
	localparam logic signed [SAMPLE_W-1:0] STEP_ONE = SAMPLE_W'(1);
	localparam logic signed [SAMPLE_W-1:0] STEP_ODD = SAMPLE_W'(12345);

	logic signed [SAMPLE_W-1:0] steps_default [8] = '{
		'0, STEP_MAX, STEP_MIN, STEP_MIN, STEP_MAX, STEP_ONE, '1, '0
	};
	logic signed [SAMPLE_W-1:0] steps_extreme [6] = '{
		STEP_MAX, STEP_MIN, STEP_MAX, STEP_MIN, '0, '0
	};
	logic signed [SAMPLE_W-1:0] steps_flipped [4] = '{
		STEP_MIN, STEP_MAX, STEP_ODD, '1
	};
	logic signed [SAMPLE_W-1:0] steps_zero [2] = '{'0, STEP_MAX};

	localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

	initial begin
		int coef_mode;
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: default coefficients, full-scale steps and the smallest nonzero values.
		foreach (steps_default[i])
			send_sample(steps_default[i]);
		// Extreme coefficients drive both outputs into clipping.
		load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
		foreach (steps_extreme[i])
			send_sample(steps_extreme[i]);
		load_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
		foreach (steps_flipped[i])
			send_sample(steps_flipped[i]);
		// All-zero coefficients drive the outputs, and so the output history, to zero.
		load_coefs('0, '0, '0, '0);
		foreach (steps_zero[i])
			send_sample(steps_zero[i]);

		// Random phases crossing coefficient sets with idling patterns.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			coef_mode = (p + p / 4) % 4;
			case (coef_mode)
				0: load_coefs(sqf_pkg::B0_RESET, sqf_pkg::A1_RESET,
					sqf_pkg::A2_RESET, sqf_pkg::QB0_RESET);
				1: load_coefs($urandom, $urandom, $urandom, $urandom);
				2: load_coefs(small_coef(), small_coef(), small_coef(), small_coef());
				default: begin
					if (p < 4)
						load_coefs(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX);
					else
						load_coefs(COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN);
				end
			endcase
			case (p % 4)
				0: begin
					src_idle_pct = 0;
					snk_stall_pct = 0;
				end
				1: begin
					src_idle_pct = 54;
					snk_stall_pct = 0;
				end
				2: begin
					src_idle_pct = 0;
					snk_stall_pct = 54;
				end
				default: begin
					src_idle_pct = 11;
					snk_stall_pct = 11;
				end
			endcase
			for (int i = 0; i < SAMPLES_PER_PHASE; i++) begin
				// Long receiver hold-off while samples keep coming, so the input backs up.
				if (i == 40 && p % 2 == 0)
					hold_cycles = 48 + $urandom_range(0, 32);
				// Sender pause until the core has delivered everything.
				if (i == 100)
					drain();
				send_sample(pick_sample());
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (sb.error_count == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
